[rtl/tmf_pkg.sv]
`timescale 1ns / 1ps

package tmf_pkg;

    // Default shape of the block
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 15;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 3;

    // Register reset values, truncated to the sample width where they are used
    localparam int RESET_LEFT_FOOT  = 0;
    localparam int RESET_LEFT_TOP   = 8192;
    localparam int RESET_RIGHT_TOP  = 24576;
    localparam int RESET_RIGHT_FOOT = 32767;

    // Register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LEFT_FOOT  = 3'd0,
        REG_LEFT_TOP   = 3'd1,
        REG_RIGHT_TOP  = 3'd2,
        REG_RIGHT_FOOT = 3'd3,
        REG_PEAK       = 3'd4,
        REG_LEFT_OPEN  = 3'd5,
        REG_RIGHT_OPEN = 3'd6
    } cfg_reg_t;

    // How the result of an item is formed at the end of the chain
    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_FULL = 2'd1,
        MODE_DIV  = 2'd2
    } mode_t;

    // Control that travels with an item from stage to stage
    typedef struct packed {
        logic  valid;
        mode_t mode;
    } item_ctrl_t;

endpackage

[rtl/tmf_front.sv]
`timescale 1ns / 1ps

module tmf_front
    import tmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample,
    input  logic signed [SAMPLE_WIDTH-1:0]  vertex_left_foot,
    input  logic signed [SAMPLE_WIDTH-1:0]  vertex_left_top,
    input  logic signed [SAMPLE_WIDTH-1:0]  vertex_right_top,
    input  logic signed [SAMPLE_WIDTH-1:0]  vertex_right_foot,
    input  logic        [FRACTION_BITS:0]   peak_height,
    input  logic                            left_open,
    input  logic                            right_open,
    input  logic                            down_ready,
    output item_ctrl_t                      out_ctrl,
    output logic        [SAMPLE_WIDTH-1:0]  out_rem,
    output logic        [FRACTION_BITS:0]   out_lowq,
    output logic        [SAMPLE_WIDTH-1:0]  out_den,
    output logic        [FRACTION_BITS:0]   out_h
);

    localparam int DW = FRACTION_BITS + 1;
    localparam int PW = DW + SAMPLE_WIDTH;
    localparam logic [FRACTION_BITS:0] OneQ = {1'b1, {FRACTION_BITS{1'b0}}};

    // Stage 1: classify the sample, form numerator and divisor
    item_ctrl_t                  ctrl1_reg, ctrl1_next;
    logic [SAMPLE_WIDTH-1:0]     num1_reg, num1_next;
    logic [SAMPLE_WIDTH-1:0]     den1_reg, den1_next;
    logic [FRACTION_BITS:0]      h1_reg, h1_next;

    // Stage 2: product height times numerator
    item_ctrl_t                  ctrl2_reg, ctrl2_next;
    logic [PW-1:0]               prod2_reg, prod2_next;
    logic [SAMPLE_WIDTH-1:0]     den2_reg;
    logic [FRACTION_BITS:0]      h2_reg;

    logic ready1, ready2;
    logic signed [SAMPLE_WIDTH:0] x_minus_a, b_minus_a, d_minus_x, d_minus_c;

    assign ready2       = !ctrl2_reg.valid || down_ready;
    assign ready1       = !ctrl1_reg.valid || ready2;
    assign sample_ready = ready1;

    assign x_minus_a = {sample[SAMPLE_WIDTH-1], sample}
                     - {vertex_left_foot[SAMPLE_WIDTH-1], vertex_left_foot};
    assign b_minus_a = {vertex_left_top[SAMPLE_WIDTH-1], vertex_left_top}
                     - {vertex_left_foot[SAMPLE_WIDTH-1], vertex_left_foot};
    assign d_minus_x = {vertex_right_foot[SAMPLE_WIDTH-1], vertex_right_foot}
                     - {sample[SAMPLE_WIDTH-1], sample};
    assign d_minus_c = {vertex_right_foot[SAMPLE_WIDTH-1], vertex_right_foot}
                     - {vertex_right_top[SAMPLE_WIDTH-1], vertex_right_top};

    // Region tests in fixed order: outside, rising, plateau, falling
    always_comb
    begin
        ctrl1_next.valid = sample_valid;
        ctrl1_next.mode  = MODE_ZERO;
        num1_next        = x_minus_a[SAMPLE_WIDTH-1:0];
        den1_next        = b_minus_a[SAMPLE_WIDTH-1:0];
        h1_next          = (peak_height > OneQ) ? OneQ : peak_height;
        if ((!left_open && sample < vertex_left_foot)
            || (!right_open && sample > vertex_right_foot))
        begin
            ctrl1_next.mode = MODE_ZERO;
        end
        else if (sample < vertex_left_top)
        begin
            ctrl1_next.mode = left_open ? MODE_FULL : MODE_DIV;
        end
        else if (sample <= vertex_right_top || right_open)
        begin
            ctrl1_next.mode = MODE_FULL;
        end
        else if (sample < vertex_right_foot)
        begin
            ctrl1_next.mode = MODE_DIV;
            num1_next       = d_minus_x[SAMPLE_WIDTH-1:0];
            den1_next       = d_minus_c[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            ctrl1_next.mode = MODE_ZERO;
        end
    end

    // Multiply; quotient bits come from the divider chain
    always_comb
    begin
        ctrl2_next = ctrl1_reg;
        prod2_next = PW'(num1_reg) * PW'(h1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end
        else
        begin
            if (ready1)
            begin
                ctrl1_reg <= ctrl1_next;
            end
            if (ready2)
            begin
                ctrl2_reg <= ctrl2_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            num1_reg <= num1_next;
            den1_reg <= den1_next;
            h1_reg   <= h1_next;
        end
        if (ready2)
        begin
            prod2_reg <= prod2_next;
            den2_reg  <= den1_reg;
            h2_reg    <= h1_reg;
        end
    end

    assign out_ctrl = ctrl2_reg;
    assign out_rem  = prod2_reg[PW-1:DW];
    assign out_lowq = prod2_reg[DW-1:0];
    assign out_den  = den2_reg;
    assign out_h    = h2_reg;

endmodule

[rtl/tmf_div_cell.sv]
`timescale 1ns / 1ps

module tmf_div_cell
    import tmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  item_ctrl_t                   in_ctrl,
    input  logic [SAMPLE_WIDTH-1:0]      in_rem,
    input  logic [FRACTION_BITS:0]       in_lowq,
    input  logic [SAMPLE_WIDTH-1:0]      in_den,
    input  logic [FRACTION_BITS:0]       in_h,
    output logic                         up_ready,
    input  logic                         down_ready,
    output item_ctrl_t                   out_ctrl,
    output logic [SAMPLE_WIDTH-1:0]      out_rem,
    output logic [FRACTION_BITS:0]       out_lowq,
    output logic [SAMPLE_WIDTH-1:0]      out_den,
    output logic [FRACTION_BITS:0]       out_h
);

    item_ctrl_t                 ctrl_reg;
    logic [SAMPLE_WIDTH-1:0]    rem_reg, rem_next;
    logic [FRACTION_BITS:0]     lowq_reg, lowq_next;
    logic [SAMPLE_WIDTH-1:0]    den_reg;
    logic [FRACTION_BITS:0]     h_reg;
    logic [SAMPLE_WIDTH+1:0]    trial;

    assign up_ready = !ctrl_reg.valid || down_ready;

    // One restoring step: bring down the next dividend bit, try to subtract
    always_comb
    begin
        trial = {1'b0, in_rem, in_lowq[FRACTION_BITS]} - {2'b00, in_den};
        if (!trial[SAMPLE_WIDTH+1])
        begin
            rem_next  = trial[SAMPLE_WIDTH-1:0];
            lowq_next = {in_lowq[FRACTION_BITS-1:0], 1'b1};
        end
        else
        begin
            rem_next  = {in_rem[SAMPLE_WIDTH-2:0], in_lowq[FRACTION_BITS]};
            lowq_next = {in_lowq[FRACTION_BITS-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (up_ready)
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            rem_reg  <= rem_next;
            lowq_reg <= lowq_next;
            den_reg  <= in_den;
            h_reg    <= in_h;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_rem  = rem_reg;
    assign out_lowq = lowq_reg;
    assign out_den  = den_reg;
    assign out_h    = h_reg;

endmodule

[rtl/trapezoid_membership_core.sv]
`timescale 1ns / 1ps

// Trapezoidal fuzzy membership. Each sample item gives one degree item:
// 0 outside [a,d], height*(x-a)/(b-a) on the rising edge, the full height on
// the plateau [b,c] and on an open shoulder, height*(d-x)/(d-c) on the
// falling edge, edge values truncated. The block takes one item per clock
// while degree_ready is held high and passes it through FRACTION_BITS+3
// register stages: two front stages (classify, multiply) and then a chain
// of FRACTION_BITS+1 divider cells, each producing one quotient bit. Every
// stage has its own valid bit and stalls only when the stage ahead of it is
// full, so bubbles are squeezed out while the output waits. Write
// configuration only when no items are in flight.

module trapezoid_membership_core
    import tmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [((SAMPLE_WIDTH > FRACTION_BITS + 1) ?
                   SAMPLE_WIDTH : FRACTION_BITS + 1)-1:0] cfg_data,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample,
    output logic                              degree_valid,
    input  logic                              degree_ready,
    output logic [FRACTION_BITS:0]            degree
);

    localparam int NCELL = FRACTION_BITS + 1;

    // Configuration registers
    logic signed [SAMPLE_WIDTH-1:0] left_foot_reg, left_top_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_top_reg, right_foot_reg;
    logic        [FRACTION_BITS:0]  peak_reg;
    logic                           left_open_reg, right_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_foot_reg  <= SAMPLE_WIDTH'(RESET_LEFT_FOOT);
            left_top_reg   <= SAMPLE_WIDTH'(RESET_LEFT_TOP);
            right_top_reg  <= SAMPLE_WIDTH'(RESET_RIGHT_TOP);
            right_foot_reg <= SAMPLE_WIDTH'(RESET_RIGHT_FOOT);
            peak_reg       <= {1'b1, {FRACTION_BITS{1'b0}}};
            left_open_reg  <= 1'b0;
            right_open_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEFT_FOOT:  left_foot_reg  <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_LEFT_TOP:   left_top_reg   <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_RIGHT_TOP:  right_top_reg  <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_RIGHT_FOOT: right_foot_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_PEAK:       peak_reg       <= cfg_data[FRACTION_BITS:0];
                REG_LEFT_OPEN:  left_open_reg  <= cfg_data[0];
                REG_RIGHT_OPEN: right_open_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Stage links: index 0 is the front end, NCELL the last cell
    item_ctrl_t                 ctrl_w [NCELL+1];
    logic [SAMPLE_WIDTH-1:0]    rem_w  [NCELL+1];
    logic [FRACTION_BITS:0]     lowq_w [NCELL+1];
    logic [SAMPLE_WIDTH-1:0]    den_w  [NCELL+1];
    logic [FRACTION_BITS:0]     h_w    [NCELL+1];
    logic                       rdy_w  [NCELL+1];

    tmf_front #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .sample            (sample),
        .vertex_left_foot  (left_foot_reg),
        .vertex_left_top   (left_top_reg),
        .vertex_right_top  (right_top_reg),
        .vertex_right_foot (right_foot_reg),
        .peak_height       (peak_reg),
        .left_open         (left_open_reg),
        .right_open        (right_open_reg),
        .down_ready        (rdy_w[0]),
        .out_ctrl          (ctrl_w[0]),
        .out_rem           (rem_w[0]),
        .out_lowq          (lowq_w[0]),
        .out_den           (den_w[0]),
        .out_h             (h_w[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        tmf_div_cell #(
            .SAMPLE_WIDTH  (SAMPLE_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_ctrl    (ctrl_w[i]),
            .in_rem     (rem_w[i]),
            .in_lowq    (lowq_w[i]),
            .in_den     (den_w[i]),
            .in_h       (h_w[i]),
            .up_ready   (rdy_w[i]),
            .down_ready (rdy_w[i+1]),
            .out_ctrl   (ctrl_w[i+1]),
            .out_rem    (rem_w[i+1]),
            .out_lowq   (lowq_w[i+1]),
            .out_den    (den_w[i+1]),
            .out_h      (h_w[i+1])
        );
    end

    // Output side; the last cell is the output register
    assign rdy_w[NCELL]  = degree_ready;
    assign degree_valid  = ctrl_w[NCELL].valid;

    always_comb
    begin
        case (ctrl_w[NCELL].mode)
            MODE_ZERO: degree = '0;
            MODE_FULL: degree = h_w[NCELL];
            default:   degree = lowq_w[NCELL];
        endcase
    end

endmodule

[rtl/tmf_checker.sv]
`timescale 1ns / 1ps

module tmf_checker
    import tmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_valid,
    input logic                   sample_ready,
    input logic                   degree_valid,
    input logic                   degree_ready,
    input logic [FRACTION_BITS:0] degree
);

    localparam int DEPTH = FRACTION_BITS + 3;
    localparam int CW    = $clog2(DEPTH + 2) + 1;
    localparam logic [FRACTION_BITS:0] OneQ = {1'b1, {FRACTION_BITS{1'b0}}};

    // Items inside the block
    logic [CW-1:0] occ_reg, occ_next;
    logic          take_in, take_out;

    assign take_in  = sample_valid && sample_ready;
    assign take_out = degree_valid && degree_ready;

    always_comb
    begin
        occ_next = occ_reg + CW'(take_in) - CW'(take_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Nothing comes out while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !degree_valid)
        else $error("degree valid during reset");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        degree_valid && !degree_ready |=> degree_valid)
        else $error("degree item dropped while stalled");

    // No result without an item inside
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        degree_valid |-> occ_reg != '0)
        else $error("degree item without a sample item");

    // The pipeline never holds more items than it has stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("more items in flight than stages");

    // A degree never exceeds one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        degree_valid |-> degree <= OneQ)
        else $error("degree above one");

endmodule

bind trapezoid_membership_core tmf_checker #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
) u_tmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .degree_valid (degree_valid),
    .degree_ready (degree_ready),
    .degree       (degree)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import tmf_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int DW           = FRACTION_BITS_DEF + 1;
    localparam int CW           = (SW > DW) ? SW : DW;
    localparam longint ONE_Q    = longint'(1) << FRACTION_BITS_DEF;
    localparam int PIPE_LATENCY = FRACTION_BITS_DEF + 3;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 50;
    localparam int RANDOM_PHASES = 10;

    // Index with no register behind it
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CW-1:0]              cfg_data;
    logic                       sample_valid;
    logic                       sample_ready;
    logic signed [SW-1:0]       sample;
    logic                       degree_valid;
    logic                       degree_ready;
    logic [DW-1:0]              degree;

    // Shadow copy of the shape registers
    logic signed [SW-1:0] shape_left_foot;
    logic signed [SW-1:0] shape_left_top;
    logic signed [SW-1:0] shape_right_top;
    logic signed [SW-1:0] shape_right_foot;
    logic [CW-1:0]        shape_peak;
    logic                 shape_left_open;
    logic                 shape_right_open;

    logic [DW-1:0] degree_expected[$];

    int  error_count   = 0;
    int  samples_sent  = 0;
    int  degrees_seen  = 0;
    int  shape_count   = 0;
    int  hold_left     = 0;
    bit  no_idle       = 1'b0;

    trapezoid_membership_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .degree_valid (degree_valid),
        .degree_ready (degree_ready),
        .degree       (degree)
    );

    always #2 clk = ~clk;

    // Edge value: floor(h*num/den), clamped to h
    function automatic longint edge_ratio(longint h, longint num, longint den);
        longint q;
        q = (h * num) / den;
        return (q > h) ? h : q;
    endfunction

    // Membership degree of one sample under the shadow shape
    function automatic logic [DW-1:0] predict_degree(logic signed [SW-1:0] x);
        longint xv;
        longint a;
        longint b;
        longint c;
        longint d;
        longint h;
        longint q;
        xv = x;
        a  = shape_left_foot;
        b  = shape_left_top;
        c  = shape_right_top;
        d  = shape_right_foot;
        h  = longint'(shape_peak);
        if (h > ONE_Q)
            h = ONE_Q;
        if ((!shape_left_open && xv < a) || (!shape_right_open && xv > d))
            q = 0;
        else if (xv < b)
            q = shape_left_open ? h : edge_ratio(h, xv - a, b - a);
        else if (xv <= c)
            q = h;
        else if (shape_right_open)
            q = h;
        else if (xv < d)
            q = edge_ratio(h, d - xv, d - c);
        else
            q = 0;
        return q[DW-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Result checker and receiver ready generation
    initial
    begin
        logic [DW-1:0] want;
        degree_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && degree_valid && degree_ready)
            begin
                degrees_seen++;
                if (degree_expected.size() == 0)
                    report_mismatch($sformatf("unexpected degree %0d", degree));
                else
                begin
                    want = degree_expected.pop_front();
                    if (degree !== want)
                        report_mismatch($sformatf("degree %0d, expected %0d", degree, want));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                degree_ready <= 1'b0;
            end
            else
                degree_ready <= no_idle || ($urandom_range(0, 99) >= 15);
        end
    end

    // One sample item through the input handshake
    task automatic send_sample(input logic signed [SW-1:0] x);
        while (!no_idle && $urandom_range(0, 99) < 15)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= x;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        degree_expected.push_back(predict_degree(x));
        samples_sent++;
    endtask

    // Let every item in flight come out, then a few more cycles
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (degree_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_LEFT_FOOT:  shape_left_foot  = val[SW-1:0];
            REG_LEFT_TOP:   shape_left_top   = val[SW-1:0];
            REG_RIGHT_TOP:  shape_right_top  = val[SW-1:0];
            REG_RIGHT_FOOT: shape_right_foot = val[SW-1:0];
            REG_PEAK:       shape_peak       = val;
            REG_LEFT_OPEN:  shape_left_open  = val[0];
            REG_RIGHT_OPEN: shape_right_open = val[0];
            default: ;
        endcase
    endtask

    // Full shape rewrite while idle
    task automatic set_shape(input logic [SW-1:0] a, input logic [SW-1:0] b,
                             input logic [SW-1:0] c, input logic [SW-1:0] d,
                             input logic [CW-1:0] h, input logic lo, input logic ro);
        wait_drained();
        write_reg(REG_LEFT_FOOT, CW'(a));
        write_reg(REG_LEFT_TOP, CW'(b));
        write_reg(REG_RIGHT_TOP, CW'(c));
        write_reg(REG_RIGHT_FOOT, CW'(d));
        write_reg(REG_PEAK, h);
        write_reg(REG_LEFT_OPEN, CW'(lo));
        write_reg(REG_RIGHT_OPEN, CW'(ro));
        cfg_write <= 1'b0;
        shape_count++;
    endtask

    // Reset shape: feet, tops, both edges and the right foot itself
    task automatic test_reset_shape();
        send_sample(-16'sd32768);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(16'sd4097);
        send_sample(16'sd8191);
        send_sample(16'sd8192);
        send_sample(16'sd24576);
        send_sample(16'sd24577);
        send_sample(16'sd32766);
        send_sample(16'sd32767);
    endtask

    // Open shoulders, first on the left side and then on the right side
    task automatic test_shoulders();
        set_shape(16'sd100, 16'sd200, 16'sd300, 16'sd400, CW'(ONE_Q), 1'b1, 1'b0);
        send_sample(-16'sd32768);
        send_sample(16'sd199);
        send_sample(16'sd350);
        set_shape(16'sd100, 16'sd200, 16'sd300, 16'sd400, CW'(ONE_Q), 1'b0, 1'b1);
        send_sample(16'sd301);
        send_sample(16'sd400);
        send_sample(16'sd32767);
        send_sample(16'sd150);
    endtask

    // Heights of zero, one step, above one, and the widest/narrowest edges
    task automatic test_heights();
        set_shape(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, '1, 1'b0, 1'b0);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd32766);
        set_shape(16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'd0, 1'b0, 1'b0);
        send_sample(16'sd1);
        set_shape(-16'sd5, -16'sd4, 16'sd4, 16'sd5, 16'd1, 1'b0, 1'b0);
        send_sample(-16'sd5);
        send_sample(16'sd0);
        set_shape(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'd32767, 1'b0, 1'b0);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
    endtask

    // Vertices out of order, then a write to the unused index
    task automatic test_unordered_and_unused();
        set_shape(16'sd10000, -16'sd5000, 16'sd0, 16'sd20000, CW'(ONE_Q), 1'b0, 1'b0);
        send_sample(16'sd15000);
        send_sample(16'sd10000);
        wait_drained();
        write_reg(REG_UNUSED, '1);
        cfg_write <= 1'b0;
        send_sample(16'sd12000);
    endtask

    function automatic logic [SW-1:0] pick_sample();
        int base;
        if ($urandom_range(0, 1) == 0)
            return SW'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0: base = shape_left_foot;
            1: base = shape_left_top;
            2: base = shape_right_top;
            default: base = shape_right_foot;
        endcase
        return SW'(base + int'($urandom_range(0, 6)) - 3);
    endfunction

    // Random shapes, each followed by a batch of random samples
    task automatic test_random_shapes();
        int vals[4];
        logic [CW-1:0] h;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int i = 0; i < 4; i++)
                vals[i] = int'($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(0, 99) < 80)
                vals.sort();
            if ($urandom_range(0, 99) < 10)
                vals[$urandom_range(1, 3)] = vals[0];
            case ($urandom_range(0, 99) / 15)
                0: h = CW'(ONE_Q);
                1: h = CW'($urandom_range(32769, 65535));
                default: h = CW'($urandom_range(0, 32768));
            endcase
            no_idle = (p == 3);
            set_shape(SW'(vals[0]), SW'(vals[1]), SW'(vals[2]), SW'(vals[3]), h,
                      $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample());
        end
        no_idle = 1'b0;
    endtask

    // Output stalled for a long stretch while input keeps coming
    task automatic test_backpressure();
        set_shape(-16'sd20000, -16'sd1000, 16'sd1000, 16'sd20000, 16'd30000, 1'b0, 1'b0);
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 80; n++)
            send_sample(SW'($urandom_range(0, 65535)));
    endtask

    // Safety net on run length
    initial
    begin
        #2ms;
        $display("[trapezoid_membership_core] ERROR");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        sample_valid <= 1'b0;
        sample       <= '0;
        shape_left_foot  = SW'(RESET_LEFT_FOOT);
        shape_left_top   = SW'(RESET_LEFT_TOP);
        shape_right_top  = SW'(RESET_RIGHT_TOP);
        shape_right_foot = SW'(RESET_RIGHT_FOOT);
        shape_peak       = CW'(ONE_Q);
        shape_left_open  = 1'b0;
        shape_right_open = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_shape();
        test_shoulders();
        test_heights();
        test_unordered_and_unused();
        test_random_shapes();
        test_backpressure();
        wait_drained();

        $display("run covered %0d samples over %0d shape settings, %0d degrees checked",
                 samples_sent, shape_count, degrees_seen);
        $display("shoulders, height saturation, unordered vertices and a long output stall included");
        if (error_count == 0)
            $display("[trapezoid_membership_core] OK");
        else
            $display("[trapezoid_membership_core] ERROR");
        $finish;
    end

endmodule
